// ===== hw/rtl/fctd_pkg.sv =====
// Shared constants, types and helpers for the fan curve / thermal derate unit.
// No dependencies; imported by fctd_serdiv and fan_curve_thermal_derate_unit.
`default_nettype none

package fctd_pkg;

  // Curve shape and field widths
  localparam int CURVE_POINTS = 5;
  localparam int CFG_W        = 40;
  localparam int BYTE_W       = 8;
  localparam int TEMP_W       = 12;
  localparam int SPD_W        = 8;
  localparam int FACT_W       = 9;
  localparam int RANGE_W      = 8;
  localparam int ERR_W        = 2;

  // Temperatures in sixteenths: whole degrees shifted up by four
  localparam int FRAC_W       = 4;
  localparam int DEN_W        = BYTE_W + FRAC_W;
  localparam int CMP_W        = DEN_W + 2;
  localparam int Q_SHIFT      = 8;
  localparam int NUM_W        = DEN_W + Q_SHIFT;

  // Serial arithmetic step counts
  localparam int MUL_STEPS    = SPD_W;
  localparam int DIV_STEPS    = FACT_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  // Register map
  localparam int IDX_W = 2;
  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CURVE_TEMPS    = IDX_W'(0);
  localparam cfg_idx_t REG_CURVE_SPEEDS   = IDX_W'(1);
  localparam cfg_idx_t REG_SHUTDOWN_RANGE = IDX_W'(2);

  // Reset contents of the configuration registers
  localparam logic [CFG_W-1:0]   CURVE_TEMPS_RST  = 40'd193946918171;
  localparam logic [CFG_W-1:0]   CURVE_SPEEDS_RST = 40'd1099085466649;
  localparam logic [RANGE_W-1:0] SHUTDOWN_RST     = 8'd10;

  localparam logic [SPD_W-1:0]  SPEED_FULL  = '1;
  localparam logic [FACT_W-1:0] FACTOR_UNIT = FACT_W'(256);

  // Request to the serial multiply / divide unit
  typedef struct packed {
    logic              start;
    logic              use_mul;
    logic [SPD_W-1:0]  mplier;
    logic [DEN_W-1:0]  mcand;
    logic [NUM_W-1:0]  numer;
    logic [DEN_W-1:0]  denom;
  } sd_req_t;

  // Answer from the serial unit
  typedef struct packed {
    logic              done;
    logic [FACT_W-1:0] quot;
  } sd_resp_t;

  // Byte idx of a curve register; bytes past the register read as zero
  function automatic logic [BYTE_W-1:0] curve_byte(input logic [CFG_W-1:0] value,
                                                   input int idx);
    logic [CFG_W-1:0] sh;
    sh = value >> (BYTE_W * idx);
    curve_byte = sh[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fctd_serdiv.sv =====
// Bit-serial shift-add multiplier followed by a restoring divider; a request may skip the multiply.
// One multiplier bit, then one quotient bit, per cycle. Uses fctd_pkg.
`default_nettype none

module fctd_serdiv (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fctd_pkg::sd_req_t  req,
  output fctd_pkg::sd_resp_t      resp
);
  import fctd_pkg::*;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  logic              mul_active;
  logic              div_active;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  acc;
  logic [NUM_W-1:0]  mcand;
  logic [SPD_W-1:0]  mplier;
  logic [DEN_W-1:0]  denom;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [FACT_W-1:0] quot;

  logic [NUM_W-1:0]  acc_next;
  logic              rem_ge;

  // add step of the multiplier, compare step of the divider
  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign rem_ge   = rem >= dsh;

  // phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_active <= 1'b0;
      div_active <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      priority if (req.start) begin
        mul_active <= req.use_mul;
        div_active <= !req.use_mul;
      end else if (mul_active && cnt == MUL_LAST) begin
        mul_active <= 1'b0;
        div_active <= 1'b1;
      end else if (div_active && cnt == DIV_LAST) begin
        div_active <= 1'b0;
        done       <= 1'b1;
      end else begin
        // phase held
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    priority if (req.start) begin
      cnt    <= '0;
      acc    <= '0;
      mcand  <= NUM_W'(req.mcand);
      mplier <= req.mplier;
      denom  <= req.denom;
      rem    <= req.numer;
      dsh    <= {req.denom, Q_SHIFT'(0)};
      quot   <= '0;
    end else if (mul_active) begin
      acc    <= acc_next;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (cnt == MUL_LAST) begin
        cnt <= '0;
        rem <= acc_next;
        dsh <= {denom, Q_SHIFT'(0)};
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (div_active) begin
      if (rem_ge) rem <= rem - dsh;
      quot <= {quot[FACT_W-2:0], rem_ge};
      dsh  <= dsh >> 1;
      cnt  <= cnt + 1'b1;
    end else begin
      // idle: registers hold
    end
  end

  assign resp.done = done;
  assign resp.quot = quot;

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_active && div_active))
    else $error("multiply and divide phases active together");

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(div_active))
    else $error("done without a divide phase");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !(mul_active || div_active))
    else $error("start while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/fan_curve_thermal_derate_unit.sv =====
// Top level of the fan curve controller with LED thermal derating.
// Uses fctd_pkg and the serial arithmetic unit fctd_serdiv.
`default_nettype none

// The block takes one item of two temperature samples, works on the hotter
// one and returns one result item: fan duty from a five point curve with
// linear interpolation, the LED thermal factor (Q1.8) and the sensor error
// bits. One item is worked on at a time. An item that needs no division
// goes through the accept, evaluate and finish steps; interpolation adds a
// serial multiply, handed over to a serial divide, in the bit-serial
// multiply/divide unit between evaluate and finish, and derating a serial
// divide alone; output stalls hold the finish step.
// A finished result waits in the output register while the next item is
// taken. Configuration writes are always ready and should be made while idle.
module fan_curve_thermal_derate_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire fctd_pkg::cfg_idx_t           cfg_index,
  input  wire logic [fctd_pkg::CFG_W-1:0]   cfg_data,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [fctd_pkg::TEMP_W-1:0] temp_sensor_a,
  input  wire logic signed [fctd_pkg::TEMP_W-1:0] temp_sensor_b,
  input  wire logic                         sensor_a_bad,
  input  wire logic                         sensor_b_bad,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fctd_pkg::SPD_W-1:0]        fan_duty,
  output logic                              duty_changed,
  output logic [fctd_pkg::FACT_W-1:0]       led_factor,
  output logic                              factor_written,
  output logic [fctd_pkg::ERR_W-1:0]        sensor_errors,
  output logic signed [fctd_pkg::TEMP_W-1:0] hottest_temp
);
  import fctd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_CALC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0]   curve_temps;
  logic [CFG_W-1:0]   curve_speeds;
  logic [RANGE_W-1:0] shutdown_range;

  // controller state
  logic [SPD_W-1:0]   last_speed;
  logic               full_speed_latched;

  // captured item
  logic signed [TEMP_W-1:0] t_q;
  logic [ERR_W-1:0]         err_q;

  // evaluation results held for the finish step
  logic               use_quot;
  logic               spd_neg;
  logic [SPD_W-1:0]   spd_base;
  logic               ge_top_q;
  logic               ge_lim_q;

  // evaluation logic
  logic signed [CMP_W-1:0] t_ext, top_s, lim_s, lo_s, hi_s, seg_lo, seg_hi;
  logic signed [CMP_W-1:0] x_s, d_s, r_s;
  logic [SPD_W-1:0]        seg_s0, seg_s1, s0_b, s1_b;
  logic                    seg_found, below, ge_top, ge_lim, interior, fdiv;
  logic [SPD_W-1:0]        spd_direct;

  // finish logic
  logic [SPD_W-1:0]   speed_new;
  logic [SPD_W-1:0]   ls1, ls2;
  logic               l1, l2, ch, wr;
  logic [FACT_W-1:0]  fac;
  logic               out_load;

  fctd_pkg::sd_req_t  sd_req;
  fctd_pkg::sd_resp_t sd_resp;

  fctd_serdiv u_serdiv (
    .clk  (clk),
    .rst  (rst),
    .req  (sd_req),
    .resp (sd_resp)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_temps    <= CURVE_TEMPS_RST;
      curve_speeds   <= CURVE_SPEEDS_RST;
      shutdown_range <= SHUTDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURVE_TEMPS:    curve_temps    <= cfg_data;
        REG_CURVE_SPEEDS:   curve_speeds   <= cfg_data;
        REG_SHUTDOWN_RANGE: shutdown_range <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // curve lookup and derate band on the captured temperature
  always_comb begin
    t_ext  = CMP_W'(t_q);
    top_s  = signed'({2'b00, curve_byte(curve_temps, CURVE_POINTS - 1), FRAC_W'(0)});
    r_s    = signed'({2'b00, shutdown_range, FRAC_W'(0)});
    lim_s  = top_s + r_s;
    lo_s   = signed'({2'b00, curve_byte(curve_temps, 0), FRAC_W'(0)});
    below  = t_ext < lo_s;
    ge_top = t_ext >= top_s;
    ge_lim = t_ext >= lim_s;
    seg_found = 1'b0;
    seg_lo = '0;
    seg_hi = '0;
    seg_s0 = '0;
    seg_s1 = '0;
    // first segment holding the temperature
    for (int i = 0; i < CURVE_POINTS - 1; i++) begin
      hi_s = signed'({2'b00, curve_byte(curve_temps, i + 1), FRAC_W'(0)});
      if (!seg_found &&
          t_ext >= signed'({2'b00, curve_byte(curve_temps, i), FRAC_W'(0)}) &&
          t_ext < hi_s) begin
        seg_found = 1'b1;
        seg_lo    = signed'({2'b00, curve_byte(curve_temps, i), FRAC_W'(0)});
        seg_hi    = hi_s;
        seg_s0    = curve_byte(curve_speeds, i);
        seg_s1    = curve_byte(curve_speeds, i + 1);
      end
    end
    s0_b = seg_s0;
    s1_b = seg_s1;
    interior = !below && !ge_top && seg_found;
    fdiv     = ge_top && !ge_lim;
    priority if (below) spd_direct = '0;
    else                spd_direct = SPEED_FULL;
    x_s = t_ext - seg_lo;
    d_s = seg_hi - seg_lo;
  end

  // serial unit request, issued from the evaluate step
  always_comb begin
    sd_req.start   = (state == ST_EVAL) && (interior || fdiv);
    sd_req.use_mul = interior;
    sd_req.mplier  = (s1_b < s0_b) ? s0_b - s1_b : s1_b - s0_b;
    sd_req.mcand   = x_s[DEN_W-1:0];
    sd_req.numer   = interior ? NUM_W'(0)
                              : {NUM_W'(lim_s - t_ext)} << Q_SHIFT;
    sd_req.denom   = interior ? d_s[DEN_W-1:0] : r_s[DEN_W-1:0];
  end

  // fan update, derate, and release of the full speed latch
  always_comb begin
    if (use_quot) begin
      speed_new = spd_neg ? spd_base - sd_resp.quot[SPD_W-1:0]
                          : spd_base + sd_resp.quot[SPD_W-1:0];
    end else begin
      speed_new = spd_base;
    end
    l1  = full_speed_latched;
    ls1 = last_speed;
    ch  = 1'b0;
    if (!full_speed_latched && speed_new != last_speed) begin
      ls1 = speed_new;
      ch  = 1'b1;
      l1  = speed_new == SPEED_FULL;
    end
    l2  = l1;
    ls2 = ls1;
    wr  = 1'b0;
    fac = '0;
    priority if (ge_lim_q) begin
      wr = 1'b1;
    end else if (ge_top_q) begin
      wr  = 1'b1;
      fac = sd_resp.quot;
    end else if (l1) begin
      l2  = 1'b0;
      fac = FACTOR_UNIT;
      wr  = 1'b1;
      if (speed_new != ls1) begin
        ls2 = speed_new;
        ch  = 1'b1;
        l2  = speed_new == SPEED_FULL;
      end
    end else begin
      // below the top point and not latched: factor untouched
    end
  end

  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);
  assign in_stall = state != ST_IDLE;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: state_next = (interior || fdiv) ? ST_CALC : ST_FIN;
      ST_CALC: if (sd_resp.done) state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      last_speed         <= '0;
      full_speed_latched <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        last_speed         <= ls2;
        full_speed_latched <= l2;
        out_valid          <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and evaluation registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      t_q   <= (temp_sensor_a > temp_sensor_b) ? temp_sensor_a : temp_sensor_b;
      err_q <= {sensor_b_bad, sensor_a_bad};
    end
    if (state == ST_EVAL) begin
      use_quot <= interior;
      spd_neg  <= s1_b < s0_b;
      spd_base <= interior ? s0_b : spd_direct;
      ge_top_q <= ge_top;
      ge_lim_q <= ge_lim;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      fan_duty       <= ls2;
      duty_changed   <= ch;
      led_factor     <= fac;
      factor_written <= wr;
      sensor_errors  <= err_q;
      hottest_temp   <= t_q;
    end
  end

  a_latch_full: assert property (@(posedge clk) disable iff (rst)
    full_speed_latched |-> last_speed == SPEED_FULL)
    else $error("latched without full speed");

  a_factor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !factor_written) |-> led_factor == '0)
    else $error("factor set but not written");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> in_stall)
    else $error("input taken during arithmetic");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result lost on load");

endmodule

`default_nettype wire
